### design/time_of_day_clock_with_alarms_top_assert.svh
// Assertion macros for the time-of-day clock
`ifndef TIME_OF_DAY_CLOCK_WITH_ALARMS_TOP_ASSERT_SVH
`define TIME_OF_DAY_CLOCK_WITH_ALARMS_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TODC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("todc assertion failed");
`define TODC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("todc assertion failed");
`else
`define TODC_ASSERT_SAME(name, ante, cons)
`define TODC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### design/todc_pkg.sv
// Shared types, codes and helpers for the time-of-day clock
package todc_pkg;

    localparam int ACT_W      = 2;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int SOD_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SNOOZE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SET    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ALARM1_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM1_ON   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM2_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM2_ON   = 2'd3;

    localparam logic [HOUR_W-1:0] MAX_HOUR = 5'd23;
    localparam logic [MIN_W-1:0]  MAX_MIN  = 6'd59;
    localparam logic [SEC_W-1:0]  MAX_SEC  = 6'd59;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } hms_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [HOUR_W-1:0] hour_in;
        logic [MIN_W-1:0]  minute_in;
        logic [SEC_W-1:0]  second_in;
        logic              on_main_screen;
    } item_t;

    typedef struct packed {
        logic [SOD_W-1:0] alarm1_time;
        logic             alarm1_on;
        logic [SOD_W-1:0] alarm2_time;
        logic             alarm2_on;
    } alarm_cfg_t;

    typedef struct packed {
        hms_t             now;
        logic [SOD_W-1:0] snooze_time;
        logic             snooze_armed;
    } clock_state_t;

    typedef struct packed {
        logic refresh;
        logic alarm_fired;
    } step_flags_t;

    function automatic logic [SOD_W-1:0] sec_of_day(
        input logic [HOUR_W-1:0] h,
        input logic [MIN_W-1:0]  m,
        input logic [SEC_W-1:0]  s
    );
        logic [SOD_W-1:0] sum;
        begin
            sum = SOD_W'(h) * SOD_W'(3600) + SOD_W'(m) * SOD_W'(60) + SOD_W'(s);
            return sum;
        end
    endfunction

endpackage

### design/todc_if.sv
// Item and result channel interfaces for the time-of-day clock
interface todc_item_if;
    logic                           valid;
    logic                           ready;
    logic [todc_pkg::ACT_W-1:0]     action;
    logic [todc_pkg::HOUR_W-1:0]    hour_in;
    logic [todc_pkg::MIN_W-1:0]     minute_in;
    logic [todc_pkg::SEC_W-1:0]     second_in;
    logic                           on_main_screen;

    modport source (
        output valid, action, hour_in, minute_in, second_in, on_main_screen,
        input  ready
    );
    modport sink (
        input  valid, action, hour_in, minute_in, second_in, on_main_screen,
        output ready
    );
endinterface

interface todc_result_if;
    logic                           valid;
    logic                           ready;
    logic [todc_pkg::HOUR_W-1:0]    hour_out;
    logic [todc_pkg::MIN_W-1:0]     minute_out;
    logic [todc_pkg::SEC_W-1:0]     second_out;
    logic                           refresh;
    logic                           alarm_fired;

    modport source (
        output valid, hour_out, minute_out, second_out, refresh, alarm_fired,
        input  ready
    );
    modport sink (
        input  valid, hour_out, minute_out, second_out, refresh, alarm_fired,
        output ready
    );
endinterface

### design/todc_step.sv
// Next-state and result logic for one clock item
module todc_step #(
    parameter int TICKS_PER_SECOND = 5
) (
    input  todc_pkg::item_t        item_in,
    input  todc_pkg::alarm_cfg_t   cfg,
    input  todc_pkg::clock_state_t cur,
    input  logic [((TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1)-1:0] tick_cur,
    output todc_pkg::clock_state_t nxt,
    output logic [((TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1)-1:0] tick_nxt,
    output todc_pkg::step_flags_t  flags
);

    localparam int TICK_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_SECOND - 1);

    todc_pkg::hms_t                 adv;
    logic                           sec_wrap;
    logic [todc_pkg::SOD_W-1:0]     adv_sod;
    logic                           alarm_hit;
    logic                           snooze_hit;

    // advance the time by one second
    always_comb
    begin
        adv      = cur.now;
        sec_wrap = (cur.now.second == todc_pkg::MAX_SEC);
        if (sec_wrap)
        begin
            adv.second = '0;
            if (cur.now.minute == todc_pkg::MAX_MIN)
            begin
                adv.minute = '0;
                adv.hour   = (cur.now.hour == todc_pkg::MAX_HOUR) ? '0 : cur.now.hour + 1'b1;
            end
            else
            begin
                adv.minute = cur.now.minute + 1'b1;
            end
        end
        else
        begin
            adv.second = cur.now.second + 1'b1;
        end
    end

    assign adv_sod    = todc_pkg::sec_of_day(adv.hour, adv.minute, adv.second);
    assign alarm_hit  = (cfg.alarm1_on && adv_sod == cfg.alarm1_time)
                     || (cfg.alarm2_on && adv_sod == cfg.alarm2_time);
    assign snooze_hit = cur.snooze_armed && adv_sod == cur.snooze_time;

    always_comb
    begin
        nxt               = cur;
        tick_nxt          = tick_cur;
        flags.refresh     = 1'b0;
        flags.alarm_fired = 1'b0;
        unique case (item_in.action)
            todc_pkg::ACT_TICK:
            begin
                if (tick_cur == TICK_LAST)
                begin
                    tick_nxt          = '0;
                    nxt.now           = adv;
                    flags.alarm_fired = alarm_hit || snooze_hit;
                    flags.refresh     = item_in.on_main_screen || sec_wrap
                                     || alarm_hit || snooze_hit;
                    if (snooze_hit)
                    begin
                        nxt.snooze_armed = 1'b0;
                    end
                end
                else
                begin
                    tick_nxt = tick_cur + 1'b1;
                end
            end
            todc_pkg::ACT_SNOOZE:
            begin
                nxt.snooze_time  = todc_pkg::sec_of_day(item_in.hour_in, item_in.minute_in,
                                                        item_in.second_in);
                nxt.snooze_armed = 1'b1;
            end
            todc_pkg::ACT_SET:
            begin
                nxt.now.hour   = (item_in.hour_in > todc_pkg::MAX_HOUR)
                               ? todc_pkg::MAX_HOUR : item_in.hour_in;
                nxt.now.minute = (item_in.minute_in > todc_pkg::MAX_MIN)
                               ? todc_pkg::MAX_MIN : item_in.minute_in;
                nxt.now.second = (item_in.second_in > todc_pkg::MAX_SEC)
                               ? todc_pkg::MAX_SEC : item_in.second_in;
                tick_nxt       = '0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### design/time_of_day_clock_with_alarms_top.sv
// Top level of the time-of-day clock with two alarms and a snooze
//
//  channel   dir   payload                                             transfer
//  item      in    action, hour_in, minute_in, second_in, on_main_scr  valid & ready
//  result    out   hour_out, minute_out, second_out, refresh, alarm_f  valid & ready
//  cfg       in    cfg_we, cfg_index, cfg_data                         cfg_we
//
// One item per cycle while the result is taken; after the item transfer the item passes
// through the item register, then the step logic into the result register.
// The time and snooze registers update in the same cycle the result register loads.
// A stalled result holds the item register; while the result waits, a new item is
// taken only into an empty item register, so at most two items are held.
// Reset clears time, prescaler, snooze and alarm registers to zero.
`include "time_of_day_clock_with_alarms_top_assert.svh"

module time_of_day_clock_with_alarms_top #(
    parameter int TICKS_PER_SECOND = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    todc_item_if.sink                          item,
    todc_result_if.source                      result,
    input  logic                               cfg_we,
    input  logic [todc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [todc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int TICK_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_SECOND - 1);

    todc_pkg::item_t        item_reg;
    logic                   item_vld_reg;
    todc_pkg::clock_state_t state_reg;
    todc_pkg::clock_state_t state_next;
    logic [TICK_W-1:0]      tick_reg;
    logic [TICK_W-1:0]      tick_next;
    todc_pkg::alarm_cfg_t   cfg_reg;
    todc_pkg::step_flags_t  flags;
    todc_pkg::hms_t         res_time_reg;
    todc_pkg::step_flags_t  res_flags_reg;
    logic                   res_vld_reg;
    logic                   step_go;
    logic                   item_take;
    logic                   time_legal;

    assign step_go    = item_vld_reg && (!res_vld_reg || result.ready);
    assign item.ready = !item_vld_reg || step_go;
    assign item_take  = item.valid && item.ready;

    todc_step #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_step (
        .item_in  (item_reg),
        .cfg      (cfg_reg),
        .cur      (state_reg),
        .tick_cur (tick_reg),
        .nxt      (state_next),
        .tick_nxt (tick_next),
        .flags    (flags)
    );

    // hold the incoming item
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg.action         <= item.action;
            item_reg.hour_in        <= item.hour_in;
            item_reg.minute_in      <= item.minute_in;
            item_reg.second_in      <= item.second_in;
            item_reg.on_main_screen <= item.on_main_screen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_vld_reg <= item.valid;
        end
    end

    // advance clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            tick_reg  <= '0;
        end
        else if (step_go)
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (step_go)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            res_time_reg  <= state_next.now;
            res_flags_reg <= flags;
        end
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                todc_pkg::REG_ALARM1_TIME: cfg_reg.alarm1_time <= cfg_data;
                todc_pkg::REG_ALARM1_ON:   cfg_reg.alarm1_on   <= cfg_data[0];
                todc_pkg::REG_ALARM2_TIME: cfg_reg.alarm2_time <= cfg_data;
                todc_pkg::REG_ALARM2_ON:   cfg_reg.alarm2_on   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign result.valid       = res_vld_reg;
    assign result.hour_out    = res_time_reg.hour;
    assign result.minute_out  = res_time_reg.minute;
    assign result.second_out  = res_time_reg.second;
    assign result.refresh     = res_flags_reg.refresh;
    assign result.alarm_fired = res_flags_reg.alarm_fired;

    assign time_legal = state_reg.now.hour <= todc_pkg::MAX_HOUR
                     && state_reg.now.minute <= todc_pkg::MAX_MIN
                     && state_reg.now.second <= todc_pkg::MAX_SEC;

    `TODC_ASSERT_SAME(a_time_range, 1'b1, time_legal)
    `TODC_ASSERT_SAME(a_tick_range, 1'b1, tick_reg <= TICK_LAST)
    `TODC_ASSERT_SAME(a_fire_refresh, res_vld_reg && res_flags_reg.alarm_fired, res_flags_reg.refresh)
    `TODC_ASSERT_NEXT(a_item_held, item_vld_reg && !step_go, item_vld_reg && $stable(item_reg))

endmodule
